// File: sv/salc_pkg.sv
// shared types, constants and sizes for the set-associative lru tag store
// no dependencies; the queue, front, back and top files import this package
package salc_pkg;

  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int ADDR_WIDTH   = 64;

  localparam int NUM_SETS  = 1 << MAX_SET_BITS;
  localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int AGE_W     = WAY_W;
  localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);

  // operation codes
  localparam logic [1:0] OP_LOAD     = 2'd0;
  localparam logic [1:0] OP_STORE    = 2'd1;
  localparam logic [1:0] OP_MODIFY   = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  // outcome codes
  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_FILL  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [1:0] CFG_WAYS       = 2'd1;
  localparam logic [1:0] CFG_BLOCK_BITS = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic        last;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
  } rsp_t;

  // effective (clamped) configuration
  typedef struct packed {
    logic [2:0]           set_bits;
    logic [WAY_CNT_W-1:0] ways;
    logic [5:0]           block_bits;
  } cfg_t;

  // one access handed from the front to the back
  typedef struct packed {
    logic [SET_W-1:0]      set;
    logic [ADDR_WIDTH-1:0] tag;
    logic                  last;
  } acc_t;

  // one set row of the tag store
  typedef struct packed {
    logic [MAX_WAYS-1:0]                 valid;
    logic [MAX_WAYS-1:0][AGE_W-1:0]      age;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag;
  } row_t;

  localparam int ROW_W = $bits(row_t);

endpackage

// File: sv/salc_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/salc_queue.sv
// two-entry access queue between front and back
// depends on salc_pkg
module salc_queue
  import salc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  acc_t data_i,
  output logic full_o,
  input  logic pop_i,
  output acc_t data_o,
  output logic empty_o
);

  acc_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// File: sv/salc_front.sv
// front end: takes input transactions, splits address into set and tag,
// expands modify into two accesses, drops reserved ones; depends on salc_pkg
module salc_front
  import salc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic push,
  input  req_t req_i,
  output logic full,
  output logic q_push_o,
  output acc_t q_data_o,
  input  logic q_full_i
);

  logic                  pend_q;
  acc_t                  pend_acc_q;
  logic                  accept, op_ok;
  logic [ADDR_WIDTH-1:0] addr, shifted, tag;
  logic [SET_W-1:0]      set_mask;
  acc_t                  new_acc;

  always_comb begin
    addr    = req_i.address[ADDR_WIDTH-1:0];
    shifted = addr >> cfg_i.block_bits;
    tag     = addr >> ({4'd0, cfg_i.set_bits} + {1'b0, cfg_i.block_bits});
    for (int i = 0; i < SET_W; i++) begin
      set_mask[i] = (i < int'(cfg_i.set_bits));
    end
    new_acc.set  = shifted[SET_W-1:0] & set_mask;
    new_acc.tag  = tag;
    new_acc.last = (req_i.operation != OP_MODIFY);
  end

  assign full     = pend_q || q_full_i;
  assign accept   = push && !full;
  assign op_ok    = (req_i.operation != OP_RESERVED);
  assign q_push_o = pend_q ? !q_full_i : (accept && op_ok);
  assign q_data_o = pend_q ? pend_acc_q : new_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (pend_q) begin
      if (!q_full_i) pend_q <= 1'b0;
    end else if (accept && req_i.operation == OP_MODIFY) begin
      pend_q <= 1'b1;
    end
  end

  // second access of a modify is the final one
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_acc_q <= {new_acc.set, new_acc.tag, 1'b1};
    end
  end

endmodule

// File: sv/salc_back.sv
// back end: set row read, tag match, lru update, row write, result buffer
// depends on salc_pkg and salc_ram
module salc_back
  import salc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  acc_t q_data_i,
  input  logic q_empty_i,
  output logic q_pop_o,
  output logic empty,
  input  logic pop,
  output rsp_t rsp_o
);

  typedef enum logic {ST_IDLE, ST_LOOK} state_e;

  state_e        state_q;
  acc_t          cur_q;
  logic          row_vld_q [NUM_SETS];
  logic [31:0]   hits_q, misses_q, evicts_q;
  rsp_t          out_q [2];
  logic          out_wr_q, out_rd_q;
  logic [1:0]    out_cnt_q;

  logic [ROW_W-1:0] ram_rdata;
  row_t          rd, wr;
  logic          row_ok, out_full, do_write, out_pop;
  logic [MAX_WAYS-1:0] in_use, v, hit_vec, empty_vec, bump;
  logic [MAX_WAYS-1:0][AGE_W-1:0] age_r;
  logic          found, any_empty;
  logic [WAY_W-1:0] hit_way, empty_way, vic_way, pick;
  logic [AGE_W-1:0] best, hit_age, max_age;
  logic [1:0]    outcome;
  logic [31:0]   hits_d, misses_d, evicts_d;
  rsp_t          res;

  function automatic logic [31:0] sat_inc(input logic [31:0] x);
    return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
  endfunction

  salc_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (do_write),
    .waddr_i(cur_q.set),
    .wdata_i(ROW_W'(wr)),
    .re_i   (q_pop_o),
    .raddr_i(q_data_i.set),
    .rdata_o(ram_rdata)
  );

  assign out_full = (out_cnt_q == 2'd2);
  assign empty    = (out_cnt_q == 2'd0);
  assign out_pop  = pop && !empty;
  assign rsp_o    = out_q[out_rd_q];
  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;
  assign do_write = (state_q == ST_LOOK) && !out_full;

  always_comb begin
    rd      = row_t'(ram_rdata);
    row_ok  = row_vld_q[cur_q.set];
    max_age = AGE_W'(cfg_i.ways - WAY_CNT_W'(1));
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w]    = (WAY_CNT_W'(w) < cfg_i.ways);
      v[w]         = row_ok && rd.valid[w];
      age_r[w]     = row_ok ? rd.age[w] : '0;
      hit_vec[w]   = in_use[w] && v[w] && (rd.tag[w] == cur_q.tag);
      empty_vec[w] = in_use[w] && !v[w];
    end
    found     = |hit_vec;
    any_empty = |empty_vec;
    hit_way   = '0;
    empty_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w])   hit_way   = WAY_W'(w);
      if (empty_vec[w]) empty_way = WAY_W'(w);
    end
    // oldest way, ties to the lowest
    best    = '0;
    vic_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use[w] && age_r[w] > best) begin
        best    = age_r[w];
        vic_way = WAY_W'(w);
      end
    end
    hit_age = age_r[hit_way];
    if (found) begin
      pick    = hit_way;
      outcome = OUT_HIT;
    end else if (any_empty) begin
      pick    = empty_way;
      outcome = OUT_FILL;
    end else begin
      pick    = vic_way;
      outcome = OUT_EVICT;
    end
    wr = rd;
    for (int w = 0; w < MAX_WAYS; w++) begin
      bump[w] = in_use[w] && (WAY_W'(w) != pick) && v[w] &&
                (!found || age_r[w] < hit_age) && (age_r[w] < max_age);
      wr.valid[w] = v[w];
      wr.age[w]   = bump[w] ? age_r[w] + AGE_W'(1) : age_r[w];
      if (WAY_W'(w) == pick) begin
        wr.valid[w] = 1'b1;
        wr.tag[w]   = cur_q.tag;
        wr.age[w]   = '0;
      end
    end
    hits_d   = found ? sat_inc(hits_q) : hits_q;
    misses_d = found ? misses_q : sat_inc(misses_q);
    evicts_d = (outcome == OUT_EVICT) ? sat_inc(evicts_q) : evicts_q;
    res.outcome        = outcome;
    res.last           = cur_q.last;
    res.hit_total      = hits_d;
    res.miss_total     = misses_d;
    res.eviction_total = evicts_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      hits_q    <= '0;
      misses_q  <= '0;
      evicts_q  <= '0;
      out_wr_q  <= 1'b0;
      out_rd_q  <= 1'b0;
      out_cnt_q <= 2'd0;
      for (int s = 0; s < NUM_SETS; s++) row_vld_q[s] <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (q_pop_o) state_q <= ST_LOOK;
        end
        ST_LOOK: begin
          if (do_write) begin
            state_q              <= ST_IDLE;
            hits_q               <= hits_d;
            misses_q             <= misses_d;
            evicts_q             <= evicts_d;
            row_vld_q[cur_q.set] <= 1'b1;
            out_wr_q             <= ~out_wr_q;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (out_pop) out_rd_q <= ~out_rd_q;
      if (do_write && !out_pop) begin
        out_cnt_q <= out_cnt_q + 2'd1;
      end else if (out_pop && !do_write) begin
        out_cnt_q <= out_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o)  cur_q <= q_data_i;
    if (do_write) out_q[out_wr_q] <= res;
  end

endmodule

// File: sv/set_assoc_lru_cache_sim.sv
// top level of the set-associative lru tag store model
// depends on salc_pkg, salc_front, salc_queue, salc_back (and salc_ram)
//
//  channel   handshake             payload      transfers when
//  input     push / full           req_i        push && !full
//  result    empty / pop           rsp_o        pop && !empty
//  config    cfg_we_i              cfg_idx_i,   cfg_we_i
//                                  cfg_data_i
//
// each access goes through the back-end states idle, where the set row is
// read from the tag ram, and look, where it is matched, the lru updated and
// the row written back once the result buffer has room; a new access is taken
// only after the last is written back; a load or store gives one result, a
// modify two; an item with the reserved operation code is taken but gives no result
// reset clears all set rows at once through per-set valid flops, so there
// is no clearing pass; counters and configuration reset immediately
// the front keeps taking items until the 2-entry access queue fills or the second
// access of a modify waits for it, and the back keeps working until its 2-entry result buffer fills
module set_assoc_lru_cache_sim
  import salc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [5:0] cfg_data_i,
  input  logic       push,
  input  req_t       req_i,
  output logic       full,
  output logic       empty,
  input  logic       pop,
  output rsp_t       rsp_o
);

  // raw configuration registers
  logic [2:0] set_bits_q;
  logic [3:0] ways_q;
  logic [5:0] block_bits_q;
  cfg_t       cfg;

  // access queue wiring
  logic q_push, q_full, q_pop, q_empty;
  acc_t q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= 3'd4;
      ways_q       <= 4'd1;
      block_bits_q <= 6'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SET_BITS:   set_bits_q   <= cfg_data_i[2:0];
        CFG_WAYS:       ways_q       <= cfg_data_i[3:0];
        CFG_BLOCK_BITS: block_bits_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp to the sizes the store was built for
  always_comb begin
    cfg.set_bits   = (int'(set_bits_q) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_q;
    if (ways_q == 4'd0) begin
      cfg.ways = WAY_CNT_W'(1);
    end else if (int'(ways_q) > MAX_WAYS) begin
      cfg.ways = WAY_CNT_W'(MAX_WAYS);
    end else begin
      cfg.ways = WAY_CNT_W'(ways_q);
    end
    cfg.block_bits = block_bits_q;
  end

  salc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .push    (push),
    .req_i   (req_i),
    .full    (full),
    .q_push_o(q_push),
    .q_data_o(q_wdata),
    .q_full_i(q_full)
  );

  salc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  salc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .q_data_i (q_rdata),
    .q_empty_i(q_empty),
    .q_pop_o  (q_pop),
    .empty    (empty),
    .pop      (pop),
    .rsp_o    (rsp_o)
  );

endmodule
